>>> rtl/tlv_pkg.sv
// Types and constants for the TLV tag/value extractor.
// No dependencies; imported by tlv_tag_value_extractor.
package tlv_pkg;

   typedef enum logic [1:0] {
      PH_TAG,
      PH_LEAD,
      PH_LENB,
      PH_VALUE
   } phase_type;

   typedef enum logic [1:0] {
      ST_VALUE,
      ST_EMPTY,
      ST_NOT_FOUND,
      ST_SIZE_ERROR
   } status_type;

   // Register indexes on the csr port
   localparam logic [2:0] REG_TARGET_TAG         = 3'd0;
   localparam logic [2:0] REG_TARGET_TAG_BYTES   = 3'd1;
   localparam logic [2:0] REG_TWO_BYTE_LEADS     = 3'd2;
   localparam logic [2:0] REG_TWO_BYTE_COUNT     = 3'd3;
   localparam logic [2:0] REG_THREE_BYTE_PFX     = 3'd4;
   localparam logic [2:0] REG_THREE_BYTE_COUNT   = 3'd5;
   localparam logic [2:0] REG_FOUR_BYTE_PFX      = 3'd6;
   localparam logic [2:0] REG_FOUR_BYTE_COUNT    = 3'd7;

   localparam int CSR_DATA_W = 64;

   // Long-form length leads
   localparam logic [7:0] LEN_LEAD_MIN = 8'h81;
   localparam logic [7:0] LEN_LEAD_MAX = 8'h84;

   typedef struct packed {
      phase_type   phase;
      logic [23:0] held;
      logic [2:0]  seen;
      logic [2:0]  len_left;
      logic [31:0] value_left;
      logic        match;
      logic        done;
   } parse_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
      status_type status;
      logic       last;
   } emit_type;

   typedef struct packed {
      parse_type   st;
      emit_type    res;
      logic [1:0]  n_extra;
      logic [15:0] extra;
   } feed_type;

   localparam parse_type PARSE_RESET = '{
      phase: PH_TAG, held: '0, seen: '0, len_left: '0,
      value_left: '0, match: 1'b0, done: 1'b0};

endpackage

>>> rtl/tlv_tag_value_extractor.sv
// TLV tag/value extractor: finds a configured tag in a byte stream and returns its value.
// Depends on tlv_pkg.
//
//   channel | dir | payload                                   | done when
//   req_    | in  | tdata[7:0] data_byte, tlast final_byte    | tvalid & tready
//   rsp_    | out | tdata[7:0] value_byte, tuser[1:0] status, | tvalid & tready
//           |     | tlast last_result                         |
//   csr_    | in  | wr_en, index[2:0], wdata[63:0]            | wr_en
//
// One request per cycle while rsp_ is not stalled; a result passes through the input
// register, then the parse logic into the result register.
// Held tag bytes that turn out to be past the tag end are re-parsed in the same cycle.
// Synchronous active-high reset clears parse state and csr registers, tag bytes to 1.
// A stalled rsp_ holds the input register; req_tready drops only while both are full.
module tlv_tag_value_extractor #(
   parameter int TWO_BYTE_ENTRIES   = 8,
   parameter int THREE_BYTE_ENTRIES = 4,
   parameter int FOUR_BYTE_ENTRIES  = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] data_byte
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] value_byte
   output logic [1:0]                     rsp_tuser,   // [1:0] status
   output logic                           rsp_tlast,
   input  logic                           csr_wr_en,
   input  logic [2:0]                     csr_index,
   input  logic [tlv_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tlv_pkg::*;

   localparam int LEADS_W = 8 * TWO_BYTE_ENTRIES;
   localparam int PFX3_W  = 16 * THREE_BYTE_ENTRIES;
   localparam int PFX4_W  = 24 * FOUR_BYTE_ENTRIES;

   logic [31:0]        target_ff;
   logic [2:0]         tag_bytes_ff;
   logic [LEADS_W-1:0] leads_ff;
   logic [3:0]         lead_cnt_ff;
   logic [PFX3_W-1:0]  pfx3_ff;
   logic [2:0]         pfx3_cnt_ff;
   logic [PFX4_W-1:0]  pfx4_ff;
   logic [1:0]         pfx4_cnt_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   parse_type  st_ff, st_in;
   emit_type   rsp_ff, rsp_in;
   logic       advance;

   // ---- csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         tag_bytes_ff <= 3'd1;
         leads_ff     <= '0;
         lead_cnt_ff  <= '0;
         pfx3_ff      <= '0;
         pfx3_cnt_ff  <= '0;
         pfx4_ff      <= '0;
         pfx4_cnt_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_TARGET_TAG:       target_ff    <= csr_wdata[31:0];
            REG_TARGET_TAG_BYTES: tag_bytes_ff <= csr_wdata[2:0];
            REG_TWO_BYTE_LEADS:   leads_ff     <= csr_wdata[LEADS_W-1:0];
            REG_TWO_BYTE_COUNT:   lead_cnt_ff  <= csr_wdata[3:0];
            REG_THREE_BYTE_PFX:   pfx3_ff      <= csr_wdata[PFX3_W-1:0];
            REG_THREE_BYTE_COUNT: pfx3_cnt_ff  <= csr_wdata[2:0];
            REG_FOUR_BYTE_PFX:    pfx4_ff      <= csr_wdata[PFX4_W-1:0];
            REG_FOUR_BYTE_COUNT:  pfx4_cnt_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // ---- end of a tag/length header
   function automatic feed_type header_done(feed_type r);
      feed_type o;
      o = r;
      if (o.st.value_left != 32'd0) begin
         o.st.phase = PH_VALUE;
      end else if (o.st.match) begin
         o.res  = '{valid: 1'b1, value: 8'd0, status: ST_EMPTY, last: 1'b1};
         o.st.done = 1'b1;
      end else begin
         o.st.phase = PH_TAG;
      end
      return o;
   endfunction

   // ---- one byte through the parser; may hand back up to two held bytes
   function automatic feed_type feed1(parse_type s, logic [7:0] b);
      feed_type    r;
      logic [31:0] h;
      logic [2:0]  k;
      logic [2:0]  len;
      logic [7:0]  f1, f2, f3;
      logic        w4, w3, w2;
      logic [1:0]  xn;
      logic [31:0] tag, mask, vl;
      logic [23:0] p4;
      logic [15:0] p3;
      r    = '{st: s, res: '0, n_extra: 2'd0, extra: 16'd0};
      h    = {s.held, b};
      k    = s.seen + 3'd1;
      f1   = 8'd0;
      f2   = 8'd0;
      f3   = 8'd0;
      w4   = 1'b0;
      w3   = 1'b0;
      w2   = 1'b0;
      len  = 3'd1;
      xn   = 2'd0;
      tag  = 32'd0;
      mask = 32'd0;
      vl   = 32'd0;
      p4   = 24'd0;
      p3   = 16'd0;
      if (!s.done) begin
         case (s.phase)
            PH_TAG: begin
               case (k)
                  3'd1: f1 = h[7:0];
                  3'd2: begin
                     f1 = h[15:8];
                     f2 = h[7:0];
                  end
                  3'd3: begin
                     f1 = h[23:16];
                     f2 = h[15:8];
                     f3 = h[7:0];
                  end
                  default: f1 = h[31:24];
               endcase
               for (int i = 0; i < FOUR_BYTE_ENTRIES; i++) begin
                  p4 = pfx4_ff[24*i +: 24];
                  if (i < int'(pfx4_cnt_ff) && p4[23:16] == f1 &&
                      (k < 3'd2 || p4[15:8] == f2) && (k < 3'd3 || p4[7:0] == f3))
                     w4 = 1'b1;
               end
               for (int i = 0; i < THREE_BYTE_ENTRIES; i++) begin
                  p3 = pfx3_ff[16*i +: 16];
                  if (i < int'(pfx3_cnt_ff) && p3[15:8] == f1 &&
                      (k < 3'd2 || p3[7:0] == f2))
                     w3 = 1'b1;
               end
               for (int i = 0; i < TWO_BYTE_ENTRIES; i++) begin
                  if (i < int'(lead_cnt_ff) && leads_ff[8*i +: 8] == f1)
                     w2 = 1'b1;
               end
               if (k >= 3'd4)  len = 3'd4;
               else if (w4)    len = 3'd0;
               else if (w3)    len = (k < 3'd3) ? 3'd0 : 3'd3;
               else if (w2)    len = (k < 3'd2) ? 3'd0 : 3'd2;
               else            len = 3'd1;
               if (len == 3'd0) begin
                  r.st.held = h[23:0];
                  r.st.seen = k;
               end else begin
                  xn  = 2'(k - len);
                  tag = h >> {xn, 3'b000};
                  case (len)
                     3'd1:    mask = 32'h0000_00FF;
                     3'd2:    mask = 32'h0000_FFFF;
                     3'd3:    mask = 32'h00FF_FFFF;
                     default: mask = 32'hFFFF_FFFF;
                  endcase
                  r.st.match = (tag_bytes_ff == len) && (((target_ff ^ tag) & mask) == 32'd0);
                  r.st.held  = 24'd0;
                  r.st.seen  = 3'd0;
                  r.st.phase = PH_LEAD;
                  r.n_extra  = xn;
                  r.extra    = h[15:0];
               end
            end
            PH_LEAD: begin
               if (b inside {[LEN_LEAD_MIN:LEN_LEAD_MAX]}) begin
                  r.st.value_left = 32'd0;
                  r.st.len_left   = b[2:0];
                  r.st.phase      = PH_LENB;
               end else begin
                  r.st.value_left = {24'd0, b};
                  r = header_done(r);
               end
            end
            PH_LENB: begin
               r.st.value_left = {s.value_left[23:0], b};
               r.st.len_left   = s.len_left - 3'd1;
               if (r.st.len_left == 3'd0)
                  r = header_done(r);
            end
            PH_VALUE: begin
               vl = s.value_left - 32'd1;
               r.st.value_left = vl;
               if (s.match) begin
                  r.res = '{valid: 1'b1, value: b, status: ST_VALUE, last: (vl == 32'd0)};
                  if (vl == 32'd0)
                     r.st.done = 1'b1;
               end else if (vl == 32'd0) begin
                  r.st.phase = PH_TAG;
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   // ---- handshake
   assign advance    = in_valid_ff && (!rsp_ff.valid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // ---- parse: request byte plus any held bytes handed back
   always_comb begin
      feed_type   f0, fa, fb;
      emit_type   res;
      parse_type  nst;
      f0  = feed1(st_ff, in_byte_ff);
      res = f0.res;
      fa  = f0;
      if (f0.n_extra != 2'd0) begin
         fa = feed1(f0.st, (f0.n_extra == 2'd2) ? f0.extra[15:8] : f0.extra[7:0]);
         if (fa.res.valid)
            res = fa.res;
      end
      fb = fa;
      if (f0.n_extra == 2'd2) begin
         fb = feed1(fa.st, f0.extra[7:0]);
         if (fb.res.valid)
            res = fb.res;
      end
      nst = fb.st;
      if (in_last_ff) begin
         if (!nst.done)
            res = '{valid: 1'b1, value: 8'd0,
                    status: (nst.phase == PH_TAG && nst.seen == 3'd0) ?
                            ST_NOT_FOUND : ST_SIZE_ERROR,
                    last: 1'b1};
         nst = PARSE_RESET;
      end
      st_in  = advance ? nst : st_ff;
      rsp_in = rsp_ff;
      if (advance)
         rsp_in = res;
      else if (rsp_tready)
         rsp_in.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= PARSE_RESET;
         rsp_ff.valid <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.value  <= rsp_in.value;
      rsp_ff.status <= rsp_in.status;
      rsp_ff.last   <= rsp_in.last;
   end

   assign rsp_tvalid = rsp_ff.valid;
   assign rsp_tdata  = rsp_ff.value;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;

   // ---- checks
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> st_ff.phase == PH_TAG && st_ff.seen == 3'd0 && !st_ff.done)
      else $error("parse state not cleared after final byte");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff.seen <= 3'd3)
      else $error("more than three tag bytes held");

   a_held_only_in_tag: assert property (@(posedge clock) disable iff (reset)
      st_ff.phase != PH_TAG |-> st_ff.seen == 3'd0 && st_ff.held == 24'd0)
      else $error("tag bytes held outside tag phase");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid && rsp_ff.status != ST_VALUE |-> rsp_ff.last && rsp_ff.value == 8'd0)
      else $error("status result not final or carries data");

endmodule

>>> tb/tlv_lookup_checker.sv
`timescale 1ns / 100ps
// Checker for tlv_tag_value_extractor: tracks csr writes and request bytes, predicts each
// lookup answer and compares it field by field with the rsp_ channel. Depends on tlv_pkg.
module tlv_lookup_checker
   import tlv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [7:0]            rsp_tdata,
   input  logic [1:0]            rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    outstanding,
   output int                    checked_count,
   output int                    hit_count,
   output int                    size_error_count
);

   typedef struct {
      logic [7:0] value;
      status_type status;
      logic       last;
   } lookup_answer_type;

   lookup_answer_type answers[$];
   lookup_answer_type head;
   lookup_answer_type answer;
   logic              have_answer;
   logic [7:0]        replay[$];

   // csr copy
   logic [31:0] cfg_tag;
   logic [2:0]  cfg_tag_len;
   logic [63:0] cfg_leads;
   logic [3:0]  cfg_lead_n;
   logic [63:0] cfg_three;
   logic [2:0]  cfg_three_n;
   logic [47:0] cfg_four;
   logic [1:0]  cfg_four_n;

   // parse state
   phase_type   phase;
   logic [31:0] held_tag;
   logic [2:0]  held_count;
   logic [2:0]  len_left;
   logic [31:0] val_left;
   logic        tag_hit;
   logic        answered;

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic void clear_lookup();
      phase      = PH_TAG;
      held_tag   = '0;
      held_count = '0;
      len_left   = '0;
      val_left   = '0;
      tag_hit    = 1'b0;
      answered   = 1'b0;
      replay.delete();
   endfunction

   function automatic void give(input logic [7:0] v, input status_type s, input logic l);
      have_answer   = 1'b1;
      answer.value  = v;
      answer.status = s;
      answer.last   = l;
   endfunction

   function automatic void header_done();
      if (val_left != 0) begin
         phase = PH_VALUE;
      end else if (tag_hit) begin
         give(8'h00, ST_EMPTY, 1'b1);
         answered = 1'b1;
      end else begin
         phase = PH_TAG;
      end
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      int          k, size, spare, n, m, i;
      logic [31:0] entry, tag;
      logic [63:0] mask;
      bit          four_hit, three_hit, two_hit;
      if (answered) return;
      case (phase)
         PH_TAG: begin
            held_tag   = {held_tag[23:0], b};
            held_count = held_count + 3'd1;
            k          = held_count;
            four_hit   = 1'b0;
            three_hit  = 1'b0;
            two_hit    = 1'b0;
            if (k < 4) begin
               n = (cfg_four_n > 2) ? 2 : cfg_four_n;
               for (i = 0; i < n; i++) begin
                  entry = 32'((cfg_four >> (24 * i)) & 48'hFF_FFFF);
                  if ((entry >> (8 * (3 - k))) == held_tag) four_hit = 1'b1;
               end
               m = (k < 2) ? k : 2;
               n = (cfg_three_n > 4) ? 4 : cfg_three_n;
               for (i = 0; i < n; i++) begin
                  entry = 32'((cfg_three >> (16 * i)) & 64'hFFFF);
                  if ((entry >> (8 * (2 - m))) == (held_tag >> (8 * (k - m))))
                     three_hit = 1'b1;
               end
               n = (cfg_lead_n > 8) ? 8 : cfg_lead_n;
               for (i = 0; i < n; i++) begin
                  entry = 32'((cfg_leads >> (8 * i)) & 64'hFF);
                  if (entry == (held_tag >> (8 * (k - 1)))) two_hit = 1'b1;
               end
            end
            if (k >= 4) size = 4;
            else if (four_hit) size = 0;
            else if (three_hit) size = (k < 3) ? 0 : 3;
            else if (two_hit) size = (k < 2) ? 0 : 2;
            else size = 1;
            if (size != 0) begin
               spare   = k - size;
               tag     = held_tag >> (8 * spare);
               mask    = (64'd1 << (8 * size)) - 64'd1;
               tag_hit = (cfg_tag_len == size) && ((64'(cfg_tag ^ tag) & mask) == 64'd0);
               // bytes held past the tag end are parsed again, oldest first
               for (i = 0; i < spare; i++) replay.push_front(held_tag[8 * i +: 8]);
               held_tag   = '0;
               held_count = '0;
               phase      = PH_LEAD;
            end
         end
         PH_LEAD: begin
            val_left = '0;
            if (b >= LEN_LEAD_MIN && b <= LEN_LEAD_MAX) begin
               len_left = 3'(b - LEN_LEAD_MIN + 8'd1);
               phase    = PH_LENB;
            end else begin
               val_left = {24'd0, b};
               header_done();
            end
         end
         PH_LENB: begin
            val_left = {val_left[23:0], b};
            len_left = len_left - 3'd1;
            if (len_left == 0) header_done();
         end
         default: begin
            val_left = val_left - 32'd1;
            if (tag_hit) begin
               give(b, ST_VALUE, val_left == 0);
               if (val_left == 0) answered = 1'b1;
            end else if (val_left == 0) begin
               phase = PH_TAG;
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_tag     = '0;
         cfg_tag_len = 3'd1;
         cfg_leads   = '0;
         cfg_lead_n  = '0;
         cfg_three   = '0;
         cfg_three_n = '0;
         cfg_four    = '0;
         cfg_four_n  = '0;
         clear_lookup();
         answers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers.size() == 0) begin
               report_mismatch($sformatf("result %h/%0d/%b with nothing expected",
                                         rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               head = answers.pop_front();
               checked_count++;
               if (rsp_tdata !== head.value)
                  report_mismatch($sformatf("value byte %h, expected %h",
                                            rsp_tdata, head.value));
               if (rsp_tuser !== head.status)
                  report_mismatch($sformatf("status %0d, expected %s",
                                            rsp_tuser, head.status.name()));
               if (rsp_tlast !== head.last)
                  report_mismatch($sformatf("last flag %b, expected %b",
                                            rsp_tlast, head.last));
               if (head.last && (head.status == ST_VALUE || head.status == ST_EMPTY))
                  hit_count++;
               if (head.status == ST_SIZE_ERROR) size_error_count++;
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_TARGET_TAG:       cfg_tag     = csr_wdata[31:0];
               REG_TARGET_TAG_BYTES: cfg_tag_len = csr_wdata[2:0];
               REG_TWO_BYTE_LEADS:   cfg_leads   = csr_wdata;
               REG_TWO_BYTE_COUNT:   cfg_lead_n  = csr_wdata[3:0];
               REG_THREE_BYTE_PFX:   cfg_three   = csr_wdata;
               REG_THREE_BYTE_COUNT: cfg_three_n = csr_wdata[2:0];
               REG_FOUR_BYTE_PFX:    cfg_four    = csr_wdata[47:0];
               REG_FOUR_BYTE_COUNT:  cfg_four_n  = csr_wdata[1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            have_answer = 1'b0;
            replay = {replay, req_tdata};
            while (replay.size() != 0) parse_byte(replay.pop_front());
            if (req_tlast) begin
               if (!answered) begin
                  if (phase == PH_TAG && held_count == 0) give(8'h00, ST_NOT_FOUND, 1'b1);
                  else give(8'h00, ST_SIZE_ERROR, 1'b1);
               end
               clear_lookup();
            end
            if (have_answer) answers = {answers, answer};
         end
      end
      outstanding <= answers.size();
   end

endmodule

>>> tb/tlv_tag_value_extractor_tb.sv
`timescale 1ns / 100ps
// Top of the tlv_tag_value_extractor testbench: clock, reset, csr setups, request frames,
// receiver stalls and the verdict. Depends on tlv_pkg, the block and tlv_lookup_checker.
module tlv_tag_value_extractor_tb;
   import tlv_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASES         = 10;
   localparam int PHASE_BYTES    = 93;

   typedef enum int {TAG_TARGET, TAG_ONE, TAG_TWO, TAG_THREE, TAG_FOUR} tag_kind_type;

   typedef struct {
      logic [31:0] tag;
      logic [2:0]  tag_len;
      logic [63:0] leads;
      logic [3:0]  lead_n;
      logic [63:0] pfx3;
      logic [2:0]  pfx3_n;
      logic [47:0] pfx4;
      logic [1:0]  pfx4_n;
   } tlv_setup_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;   // [7:0] data_byte
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;         // [7:0] value_byte
   logic [1:0]            rsp_tuser;         // [1:0] status
   logic                  rsp_tlast;
   logic                  csr_wr_en  = 1'b0;
   logic [2:0]            csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int error_count, outstanding, checked_count, hit_count, size_error_count;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int requests_sent = 0;
   int idle_cycles   = 0;
   bit hold_request  = 1'b0;

   tlv_setup_type setup;
   logic [7:0] frame[$];

   tlv_tag_value_extractor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tlv_lookup_checker lookup_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .outstanding      (outstanding),
      .checked_count    (checked_count),
      .hit_count        (hit_count),
      .size_error_count (size_error_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic void add_byte(input logic [7:0] b);
      frame = {frame, b};
   endfunction

   task automatic send_frame();
      int i;
      for (i = 0; i < frame.size(); i++) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= frame[i];
         req_tlast  <= (i == frame.size() - 1);
         do @(posedge clock); while (!req_tready);
         requests_sent++;
      end
      frame.delete();
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // wait until every expected result is back and the pipeline is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      int            phase, start, pick, elems, hit_at, e, j, n, form, cut, entries;
      logic [23:0]   entry;
      tag_kind_type  kind;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setup: one-byte target tag 00
      frame = {8'h00, 8'h00, 8'hFF};                   // empty value, trailing byte ignored
      send_frame();
      frame = {8'h05, 8'h81, 8'h02, 8'hAA, 8'hBB, 8'h00, 8'h01, 8'h7E};
      send_frame();
      frame = {8'h01, 8'h00};                          // not found
      send_frame();
      frame = {8'h01, 8'h84, 8'hFF, 8'hFF};            // cut inside long length
      send_frame();
      frame = {8'hFF};                                 // lone tag byte
      send_frame();
      frame = {8'h02, 8'h80, 8'h11};                   // 0x80 is a plain length
      send_frame();
      frame = {8'h00, 8'h03, 8'h11, 8'h22};            // cut inside the target value
      send_frame();

      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         setup.leads   = {$urandom, $urandom};
         setup.lead_n  = 4'($urandom_range(0, 15));
         setup.pfx3    = {$urandom, $urandom};
         setup.pfx3_n  = 3'($urandom_range(0, 7));
         setup.pfx4    = {16'($urandom), $urandom};
         setup.pfx4_n  = 2'($urandom_range(0, 3));
         setup.tag     = $urandom;
         setup.tag_len = 3'($urandom_range(1, 4));
         if (phase == 0) begin
            setup = '{tag: '1, tag_len: 3'd4, leads: '1, lead_n: '1,
                      pfx3: '1, pfx3_n: '1, pfx4: '1, pfx4_n: '1};
         end else if (phase == 1) begin
            setup = '{tag: '0, tag_len: 3'd7, leads: '0, lead_n: '0,
                      pfx3: '0, pfx3_n: '0, pfx4: '0, pfx4_n: '0};
         end else if (phase == 5) begin
            setup.tag_len = 3'd0;
         end else begin
            // make the target reachable through the prefix tables
            case (setup.tag_len)
               3'd2: begin
                  if (setup.lead_n == 0) setup.lead_n = 4'd1;
                  entries = (setup.lead_n > 8) ? 8 : setup.lead_n;
                  setup.tag[15:8] = setup.leads[8 * $urandom_range(0, entries - 1) +: 8];
               end
               3'd3: begin
                  if (setup.pfx3_n == 0) setup.pfx3_n = 3'd1;
                  entries = (setup.pfx3_n > 4) ? 4 : setup.pfx3_n;
                  setup.tag[23:8] = setup.pfx3[16 * $urandom_range(0, entries - 1) +: 16];
               end
               3'd4: begin
                  if (setup.pfx4_n == 0) setup.pfx4_n = 2'd1;
                  entries = (setup.pfx4_n > 2) ? 2 : setup.pfx4_n;
                  setup.tag[31:8] = setup.pfx4[24 * $urandom_range(0, entries - 1) +: 24];
               end
               default: ;
            endcase
         end
         write_reg(REG_TARGET_TAG, {32'd0, setup.tag});
         write_reg(REG_TARGET_TAG_BYTES, {61'd0, setup.tag_len});
         write_reg(REG_TWO_BYTE_LEADS, setup.leads);
         write_reg(REG_TWO_BYTE_COUNT, {60'd0, setup.lead_n});
         write_reg(REG_THREE_BYTE_PFX, setup.pfx3);
         write_reg(REG_THREE_BYTE_COUNT, {61'd0, setup.pfx3_n});
         write_reg(REG_FOUR_BYTE_PFX, {16'd0, setup.pfx4});
         write_reg(REG_FOUR_BYTE_COUNT, {62'd0, setup.pfx4_n});
         csr_wr_en <= 1'b0;

         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 47; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 47; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         if (phase == 2) hold_request = 1'b1;

         start = requests_sent;
         while (requests_sent - start < PHASE_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               // noise
               n = $urandom_range(1, 8);
               repeat (n) add_byte(8'($urandom_range(255)));
            end else if (pick < 14) begin
               // huge long-form length, cut off early
               add_byte(8'($urandom_range(255)));
               add_byte(LEN_LEAD_MAX);
               repeat (4 + $urandom_range(0, 3)) add_byte(8'($urandom_range(255)));
            end else begin
               elems  = $urandom_range(1, 5);
               hit_at = $urandom_range(0, elems);
               for (e = 0; e < elems; e++) begin
                  kind = (e == hit_at) ? TAG_TARGET : tag_kind_type'($urandom_range(1, 4));
                  case (kind)
                     TAG_TARGET: begin
                        if (setup.tag_len >= 1 && setup.tag_len <= 4) begin
                           for (j = setup.tag_len - 1; j >= 0; j--)
                              add_byte(setup.tag[8 * j +: 8]);
                        end else begin
                           add_byte(8'($urandom_range(255)));
                        end
                     end
                     TAG_TWO: begin
                        entries = (setup.lead_n > 8) ? 8 : setup.lead_n;
                        if (entries != 0)
                           add_byte(setup.leads[8 * $urandom_range(0, entries - 1) +: 8]);
                        add_byte(8'($urandom_range(255)));
                     end
                     TAG_THREE: begin
                        entries = (setup.pfx3_n > 4) ? 4 : setup.pfx3_n;
                        if (entries != 0) begin
                           entry = {8'd0, setup.pfx3[16 * $urandom_range(0, entries - 1) +: 16]};
                           add_byte(entry[15:8]);
                           add_byte(entry[7:0]);
                        end
                        add_byte(8'($urandom_range(255)));
                     end
                     TAG_FOUR: begin
                        entries = (setup.pfx4_n > 2) ? 2 : setup.pfx4_n;
                        if (entries != 0) begin
                           entry = setup.pfx4[24 * $urandom_range(0, entries - 1) +: 24];
                           add_byte(entry[23:16]);
                           add_byte(entry[15:8]);
                           add_byte(entry[7:0]);
                        end
                        add_byte(8'($urandom_range(255)));
                     end
                     default: add_byte(8'($urandom_range(255)));
                  endcase
                  n    = $urandom_range(0, 4);
                  form = $urandom_range(0, 4);
                  if (form == 0) begin
                     add_byte(8'(n));
                  end else begin
                     add_byte(8'(LEN_LEAD_MIN - 8'd1 + 8'(form)));
                     for (j = form - 1; j >= 0; j--) add_byte(8'(32'(n) >> (8 * j)));
                  end
                  repeat (n) add_byte(8'($urandom_range(255)));
               end
               if (pick < 26) begin
                  // broken frame: final flag arrives early
                  cut = $urandom_range(1, frame.size());
                  while (frame.size() > cut) void'(frame.pop_back());
               end
            end
            send_frame();
         end
      end
      settle();

      $display("Covered %0d request bytes: directed frames, then %0d csr setups", requests_sent,
               PHASES);
      $display("Checked %0d results, %0d tag hits, %0d size errors, %0d mismatches",
               checked_count, hit_count, size_error_count, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/tlv_pkg.sv
rtl/tlv_tag_value_extractor.sv
tb/tlv_lookup_checker.sv
tb/tlv_tag_value_extractor_tb.sv
